// File: sv/plm_pkg.sv
// ----------------------------------------------------------------------------
// plm_pkg
// Shared sizes, codes and types of the positional list with cursor.
// ----------------------------------------------------------------------------
package plm_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam int ACT_W = 2;
  localparam int POS_W = 5;
  localparam int ID_W  = 8;
  localparam int ST_W  = 2;
  localparam int ENT_W = 5;
  localparam int CFG_W = 5;
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  localparam logic [ACT_W-1:0] ACT_INSERT   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_REMOVE   = 2'd1;
  localparam logic [ACT_W-1:0] ACT_SET_LOOP = 2'd2;
  localparam logic [ACT_W-1:0] ACT_REPORT   = 2'd3;

  localparam logic [ST_W-1:0] ST_OK        = 2'd0;
  localparam logic [ST_W-1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [ST_W-1:0] ST_UNDERFLOW = 2'd2;
  localparam logic [ST_W-1:0] ST_BADPOS    = 2'd3;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_NOP,
    OP_INSERT,
    OP_REMOVE,
    OP_SET_LOOP
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [ST_W-1:0]  status;
    logic [IDX_W-1:0] pos;
    logic [ID_W-1:0]  item_id;
    logic             loop_enable;
  } cmd_t;

endpackage

// File: sv/plm_front.sv
// ----------------------------------------------------------------------------
// plm_front
// Takes requests, checks them against the list size and limit, and queues a
// decoded command for the back end.
// ----------------------------------------------------------------------------
module plm_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [plm_pkg::ACT_W-1:0]    in_action,
  input  logic [plm_pkg::POS_W-1:0]    in_position,
  input  logic [plm_pkg::ID_W-1:0]     in_item_id,
  input  logic                         in_loop_enable,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [plm_pkg::CFG_W-1:0]    cfg_max_size,
  input  logic [plm_pkg::CNT_W-1:0]    count,
  input  logic                         done,
  output logic                         push,
  output plm_pkg::cmd_t                cmd
);

  logic                      pend_r;
  logic                      pend_nxt;
  logic [plm_pkg::CFG_W-1:0] max_size_r;
  logic [plm_pkg::CMP_W-1:0] cnt_ext;
  logic [plm_pkg::CMP_W-1:0] pos_ext;
  logic [plm_pkg::CMP_W-1:0] max_ext;
  logic                      full;

  assign cfg_ready = 1'b1;
  assign busy      = pend_r;
  assign push      = start && !pend_r;

  assign cnt_ext = plm_pkg::CMP_W'(count);
  assign pos_ext = plm_pkg::CMP_W'(in_position);
  assign max_ext = plm_pkg::CMP_W'(max_size_r);
  assign full    = (cnt_ext >= plm_pkg::CMP_W'(plm_pkg::CAPACITY)) ||
                   ((max_size_r != '0) && (cnt_ext >= max_ext));

  always_comb begin
    cmd.op          = plm_pkg::OP_NOP;
    cmd.status      = plm_pkg::ST_OK;
    cmd.pos         = plm_pkg::IDX_W'(in_position);
    cmd.item_id     = in_item_id;
    cmd.loop_enable = in_loop_enable;
    case (in_action)
      plm_pkg::ACT_INSERT: begin
        if (full) begin
          cmd.status = plm_pkg::ST_OVERFLOW;
        end else if (pos_ext > cnt_ext) begin
          cmd.status = plm_pkg::ST_BADPOS;
        end else begin
          cmd.op = plm_pkg::OP_INSERT;
        end
      end
      plm_pkg::ACT_REMOVE: begin
        if (count == '0) begin
          cmd.status = plm_pkg::ST_UNDERFLOW;
        end else if (pos_ext >= cnt_ext) begin
          cmd.status = plm_pkg::ST_BADPOS;
        end else begin
          cmd.op = plm_pkg::OP_REMOVE;
        end
      end
      plm_pkg::ACT_SET_LOOP: begin
        if (count != '0) begin
          cmd.op = plm_pkg::OP_SET_LOOP;
        end
      end
      default: begin
        cmd.op = plm_pkg::OP_NOP;
      end
    endcase
  end

  always_comb begin
    pend_nxt = pend_r;
    if (push) begin
      pend_nxt = 1'b1;
    end else if (done) begin
      pend_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r     <= 1'b0;
      max_size_r <= '0;
    end else begin
      pend_r <= pend_nxt;
      if (cfg_valid && cfg_ready) begin
        max_size_r <= cfg_max_size;
      end
    end
  end

endmodule

// File: sv/plm_queue.sv
// ----------------------------------------------------------------------------
// plm_queue
// Small command queue between the front and back ends.
// ----------------------------------------------------------------------------
module plm_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  plm_pkg::cmd_t push_data,
  input  logic          pop,
  output logic          empty,
  output logic          full,
  output plm_pkg::cmd_t pop_data
);

  plm_pkg::cmd_t              mem_r [plm_pkg::QUEUE_DEPTH];
  logic [plm_pkg::QPTR_W-1:0] wr_ptr_r;
  logic [plm_pkg::QPTR_W-1:0] rd_ptr_r;
  logic [plm_pkg::QCNT_W-1:0] fill_r;
  logic                       do_push;
  logic                       do_pop;

  assign empty    = (fill_r == '0);
  assign full     = (fill_r == plm_pkg::QCNT_W'(plm_pkg::QUEUE_DEPTH));
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == plm_pkg::QPTR_W'(plm_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                            : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == plm_pkg::QPTR_W'(plm_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                            : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill_r <= fill_r + 1'b1;
      end else if (do_pop && !do_push) begin
        fill_r <= fill_r - 1'b1;
      end
    end
  end

endmodule

// File: sv/plm_back.sv
// ----------------------------------------------------------------------------
// plm_back
// Executes queued commands on the shifting entry array, then reports the
// cursor neighborhood of the updated array from output registers.
// ----------------------------------------------------------------------------
module plm_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      q_empty,
  input  plm_pkg::cmd_t             q_data,
  output logic                      q_pop,
  output logic [plm_pkg::CNT_W-1:0] count,
  output logic                      out_strobe,
  output logic [plm_pkg::ST_W-1:0]  out_status,
  output logic [plm_pkg::ID_W-1:0]  out_removed_item,
  output logic [plm_pkg::ENT_W-1:0] out_entry_count,
  output logic                      out_has_current,
  output logic [plm_pkg::ID_W-1:0]  out_current_item,
  output logic                      out_has_previous,
  output logic [plm_pkg::ID_W-1:0]  out_previous_item,
  output logic                      out_has_next,
  output logic [plm_pkg::ID_W-1:0]  out_next_item,
  output logic                      out_loop_active
);

  logic [plm_pkg::ID_W-1:0]  store_r   [plm_pkg::CAPACITY];
  logic [plm_pkg::ID_W-1:0]  store_nxt [plm_pkg::CAPACITY];
  logic [plm_pkg::CNT_W-1:0] count_r;
  logic [plm_pkg::CNT_W-1:0] count_nxt;
  logic [plm_pkg::IDX_W-1:0] cursor_r;
  logic [plm_pkg::IDX_W-1:0] cursor_nxt;
  logic                      loop_r;
  logic                      loop_nxt;
  logic [plm_pkg::ST_W-1:0]  status_r;
  logic [plm_pkg::ID_W-1:0]  removed_r;
  logic [plm_pkg::ID_W-1:0]  removed_nxt;
  logic                      rep_r;
  logic                      exec;

  logic                      strobe_r;
  logic [plm_pkg::ST_W-1:0]  o_status_r;
  logic [plm_pkg::ID_W-1:0]  o_removed_r;
  logic [plm_pkg::ENT_W-1:0] o_count_r;
  logic                      o_hc_r;
  logic [plm_pkg::ID_W-1:0]  o_cur_r;
  logic                      o_hp_r;
  logic [plm_pkg::ID_W-1:0]  o_prv_r;
  logic                      o_hn_r;
  logic [plm_pkg::ID_W-1:0]  o_nxt_r;
  logic                      o_loop_r;

  logic                      hc;
  logic                      hp;
  logic                      hn;
  logic [plm_pkg::ID_W-1:0]  cur_id;
  logic [plm_pkg::ID_W-1:0]  prv_id;
  logic [plm_pkg::ID_W-1:0]  nxt_id;
  logic [plm_pkg::IDX_W-1:0] last_idx;
  logic [plm_pkg::CNT_W-1:0] cur_plus1;
  logic [plm_pkg::CNT_W-1:0] cnt_dec;

  assign q_pop = !q_empty;
  assign exec  = !q_empty;
  assign count = count_r;

  // execute
  assign cnt_dec = count_r - 1'b1;

  always_comb begin
    store_nxt   = store_r;
    count_nxt   = count_r;
    cursor_nxt  = cursor_r;
    loop_nxt    = loop_r;
    removed_nxt = '0;
    case (q_data.op)
      plm_pkg::OP_INSERT: begin
        for (int i = 0; i < plm_pkg::CAPACITY; i++) begin
          if (plm_pkg::IDX_W'(i) == q_data.pos) begin
            store_nxt[i] = q_data.item_id;
          end else if (plm_pkg::IDX_W'(i) > q_data.pos) begin
            store_nxt[i] = store_r[(i > 0) ? i - 1 : 0];
          end
        end
        count_nxt = count_r + 1'b1;
        if (count_r == '0) begin
          cursor_nxt = '0;
        end else if (q_data.pos <= cursor_r) begin
          cursor_nxt = cursor_r + 1'b1;
        end
      end
      plm_pkg::OP_REMOVE: begin
        removed_nxt = store_r[q_data.pos];
        for (int i = 0; i < plm_pkg::CAPACITY; i++) begin
          if ((plm_pkg::IDX_W'(i) >= q_data.pos) && (i < plm_pkg::CAPACITY - 1)) begin
            store_nxt[i] = store_r[(i < plm_pkg::CAPACITY - 1) ? i + 1 : i];
          end
        end
        count_nxt = cnt_dec;
        if (cnt_dec == '0) begin
          cursor_nxt = '0;
        end else if (q_data.pos < cursor_r) begin
          cursor_nxt = cursor_r - 1'b1;
        end else if ((q_data.pos == cursor_r) &&
                     (plm_pkg::CNT_W'(q_data.pos) >= cnt_dec)) begin
          cursor_nxt = '0;
        end
      end
      plm_pkg::OP_SET_LOOP: begin
        loop_nxt = q_data.loop_enable;
      end
      default: begin
        loop_nxt = loop_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      store_r   <= store_nxt;
      status_r  <= q_data.status;
      removed_r <= removed_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      cursor_r <= '0;
      loop_r   <= 1'b1;
      rep_r    <= 1'b0;
    end else begin
      rep_r <= exec;
      if (exec) begin
        count_r  <= count_nxt;
        cursor_r <= cursor_nxt;
        loop_r   <= loop_nxt;
      end
    end
  end

  // report
  assign last_idx  = plm_pkg::IDX_W'(cnt_dec);
  assign cur_plus1 = plm_pkg::CNT_W'(cursor_r) + 1'b1;
  assign hc        = (count_r != '0);

  always_comb begin
    cur_id = hc ? store_r[cursor_r] : '0;
    hp     = 1'b0;
    prv_id = '0;
    hn     = 1'b0;
    nxt_id = '0;
    if (hc) begin
      if (cursor_r != '0) begin
        hp     = 1'b1;
        prv_id = store_r[cursor_r - 1'b1];
      end else if (loop_r) begin
        hp     = 1'b1;
        prv_id = store_r[last_idx];
      end
      if (cur_plus1 < count_r) begin
        hn     = 1'b1;
        nxt_id = store_r[cursor_r + 1'b1];
      end else if (loop_r) begin
        hn     = 1'b1;
        nxt_id = store_r[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rep_r) begin
      o_status_r  <= status_r;
      o_removed_r <= removed_r;
      o_count_r   <= plm_pkg::ENT_W'(count_r);
      o_hc_r      <= hc;
      o_cur_r     <= cur_id;
      o_hp_r      <= hp;
      o_prv_r     <= prv_id;
      o_hn_r      <= hn;
      o_nxt_r     <= nxt_id;
      o_loop_r    <= loop_r && hc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= rep_r;
    end
  end

  assign out_strobe        = strobe_r;
  assign out_status        = o_status_r;
  assign out_removed_item  = o_removed_r;
  assign out_entry_count   = o_count_r;
  assign out_has_current   = o_hc_r;
  assign out_current_item  = o_cur_r;
  assign out_has_previous  = o_hp_r;
  assign out_previous_item = o_prv_r;
  assign out_has_next      = o_hn_r;
  assign out_next_item     = o_nxt_r;
  assign out_loop_active   = o_loop_r;

endmodule

// File: sv/positional_list_with_cursor_unit.sv
// ----------------------------------------------------------------------------
// positional_list_with_cursor_unit
// Ordered id list with cursor and wrap mode: front end checks requests,
// back end shifts the entry array and reports the cursor neighborhood.
//
//   channel  | handshake          | payload
//   ---------+--------------------+------------------------------------------
//   in_      | start / busy       | action, position, item_id, loop_enable
//   out_     | out_strobe         | status .. loop_active, one cycle each
//   cfg_     | cfg_valid/cfg_ready| max_size
//
// A request is accepted when start is high and busy low; it is queued, then
// executed on the shifting array, and its result is registered and strobes
// on out_strobe. busy stays high one cycle, until the queued command is
// popped for execution, so a new request waits for that pop.
// Reset is synchronous, active low: empty list, cursor 0, loop mode on,
// max_size 0. Results cannot be stalled.
// ----------------------------------------------------------------------------
module positional_list_with_cursor_unit (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic [plm_pkg::ACT_W-1:0] in_action,
  input  logic [plm_pkg::POS_W-1:0] in_position,
  input  logic [plm_pkg::ID_W-1:0]  in_item_id,
  input  logic                      in_loop_enable,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [plm_pkg::CFG_W-1:0] cfg_max_size,
  output logic                      out_strobe,
  output logic [plm_pkg::ST_W-1:0]  out_status,
  output logic [plm_pkg::ID_W-1:0]  out_removed_item,
  output logic [plm_pkg::ENT_W-1:0] out_entry_count,
  output logic                      out_has_current,
  output logic [plm_pkg::ID_W-1:0]  out_current_item,
  output logic                      out_has_previous,
  output logic [plm_pkg::ID_W-1:0]  out_previous_item,
  output logic                      out_has_next,
  output logic [plm_pkg::ID_W-1:0]  out_next_item,
  output logic                      out_loop_active
);

  logic                      push;
  logic                      pop;
  logic                      q_empty;
  logic                      q_full;
  plm_pkg::cmd_t             push_cmd;
  plm_pkg::cmd_t             pop_cmd;
  logic [plm_pkg::CNT_W-1:0] count;

  plm_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_action      (in_action),
    .in_position    (in_position),
    .in_item_id     (in_item_id),
    .in_loop_enable (in_loop_enable),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_max_size   (cfg_max_size),
    .count          (count),
    .done           (pop),
    .push           (push),
    .cmd            (push_cmd)
  );

  plm_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_cmd),
    .pop       (pop),
    .empty     (q_empty),
    .full      (q_full),
    .pop_data  (pop_cmd)
  );

  plm_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_empty           (q_empty),
    .q_data            (pop_cmd),
    .q_pop             (pop),
    .count             (count),
    .out_strobe        (out_strobe),
    .out_status        (out_status),
    .out_removed_item  (out_removed_item),
    .out_entry_count   (out_entry_count),
    .out_has_current   (out_has_current),
    .out_current_item  (out_current_item),
    .out_has_previous  (out_has_previous),
    .out_previous_item (out_previous_item),
    .out_has_next      (out_has_next),
    .out_next_item     (out_next_item),
    .out_loop_active   (out_loop_active)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after accepted transfer");

  a_queue_never_full_on_push: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_full)
    else $error("command queue overrun");

  a_strobe_spacing: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("back-to-back result strobes");

  a_current_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_has_current == (out_entry_count != '0)))
    else $error("has_current disagrees with entry_count");

  a_loop_neighbors: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_loop_active) |-> (out_has_previous && out_has_next))
    else $error("loop mode without both neighbors");

endmodule
